// ===== rtl/lbc_pkg.sv =====
// shared constants, codes and types of the lru block buffer cache
package lbc_pkg;

  // number of buffers in the tag store (2 to 32)
  localparam int BUFFERS = 32;
  localparam int IDX_W   = (BUFFERS > 2) ? $clog2(BUFFERS) : 1;

  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int CNT_W   = 8;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // request codes
  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2,
    MODE_UNPIN   = 2'd3
  } lbc_mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_COUNT   = 2'd2
  } lbc_status_t;

  // one buffer as seen by the scan unit
  typedef struct packed {
    logic              valid;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] stamp;
  } lbc_entry_t;

  // verdict of the scan unit on one buffer
  typedef struct packed {
    logic is_match;
    logic is_better_free;
  } lbc_pick_t;

endpackage

// ===== rtl/lbc_scan.sv =====
// compare unit shared by every step of the buffer scan
module lbc_scan (
  input  lbc_pkg::lbc_entry_t         ent,
  input  logic [lbc_pkg::DEV_W-1:0]   device,
  input  logic [lbc_pkg::BLK_W-1:0]   block_number,
  input  logic                        free_found,
  input  logic [lbc_pkg::TIME_W-1:0]  best_time,
  output lbc_pkg::lbc_pick_t          pick
);

  // tag hit needs valid contents; a free buffer wins only if strictly older
  always_comb begin
    pick.is_match = ent.valid && (ent.device == device) && (ent.block == block_number);
    pick.is_better_free = (ent.count == '0) && (!free_found || (ent.stamp < best_time));
  end

endmodule

// ===== rtl/lru_block_buffer_cache.sv =====
// top level: buffer cache tag store with reference counts and lru replacement
//
//  channel  | handshake                  | fields
//  ---------+----------------------------+---------------------------------------------
//  request  | start, busy (in: start&!busy) | mode, device, block_number, buffer_index, now
//  result   | done (one-cycle strobe)    | slot, hit, needs_fill, status
//
//  get scans the store: one compare unit visits one buffer per cycle for the tag
//  hit and the oldest free buffer, then at most one writeback in the finish state.
//  release, pin and unpin do a read-modify-write of one count in the update state.
//  the result word appears the cycle after finish or update and busy falls with it.
//  rst (synchronous) clears all counts, release times and valid bits at once.
//  the receiver cannot stall; a new word may start as soon as busy is low.
module lru_block_buffer_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [lbc_pkg::DEV_W-1:0]     device,
  input  logic [lbc_pkg::BLK_W-1:0]     block_number,
  input  logic [4:0]                    buffer_index,
  input  logic [lbc_pkg::TIME_W-1:0]    now,
  output logic                          done,
  output logic [lbc_pkg::SLOT_W-1:0]    slot,
  output logic                          hit,
  output logic                          needs_fill,
  output logic [1:0]                    status
);

  localparam int IW = lbc_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_UPDATE
  } state_t;

  state_t state;

  // tag store
  logic [lbc_pkg::DEV_W-1:0]  tag_device     [lbc_pkg::BUFFERS];
  logic [lbc_pkg::BLK_W-1:0]  tag_block      [lbc_pkg::BUFFERS];
  logic [lbc_pkg::CNT_W-1:0]  ref_count      [lbc_pkg::BUFFERS];
  logic [lbc_pkg::TIME_W-1:0] release_time   [lbc_pkg::BUFFERS];
  logic                       contents_valid [lbc_pkg::BUFFERS];

  // latched request
  lbc_pkg::lbc_mode_t         req_mode;
  logic [lbc_pkg::DEV_W-1:0]  req_device;
  logic [lbc_pkg::BLK_W-1:0]  req_block;
  logic [4:0]                 req_index;
  logic [lbc_pkg::TIME_W-1:0] req_now;

  // scan progress
  logic [IW-1:0]              cnt;
  logic                       hit_found;
  logic [IW-1:0]              hit_idx;
  logic [lbc_pkg::CNT_W-1:0]  hit_count;
  logic                       free_found;
  logic [IW-1:0]              victim_idx;
  logic [lbc_pkg::TIME_W-1:0] victim_time;

  logic [IW-1:0]              req_idx;
  logic                       req_oor;
  logic [IW-1:0]              rd_idx;
  lbc_pkg::lbc_entry_t        ent;
  lbc_pkg::lbc_pick_t         pick;

  // write port controls
  logic                       wr_en;
  logic [IW-1:0]              wr_idx;
  logic                       wr_tag;
  logic [lbc_pkg::CNT_W-1:0]  wr_count;
  logic                       wr_stamp;

  logic [8:0]                 hit_slot_w;
  logic [8:0]                 victim_slot_w;

  assign busy          = (state != S_IDLE);
  assign req_idx       = IW'(req_index);
  assign req_oor       = (9'(req_index) >= 9'(lbc_pkg::BUFFERS));
  assign rd_idx        = (state == S_SCAN) ? cnt : req_idx;
  assign hit_slot_w    = 9'(hit_idx);
  assign victim_slot_w = 9'(victim_idx);

  // single read port of the store
  always_comb begin
    ent.valid  = contents_valid[rd_idx];
    ent.device = tag_device[rd_idx];
    ent.block  = tag_block[rd_idx];
    ent.count  = ref_count[rd_idx];
    ent.stamp  = release_time[rd_idx];
  end

  lbc_scan u_scan (
    .ent          (ent),
    .device       (req_device),
    .block_number (req_block),
    .free_found   (free_found),
    .best_time    (victim_time),
    .pick         (pick)
  );

  // writeback decision for the finishing word
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = req_idx;
    wr_tag   = 1'b0;
    wr_count = ent.count;
    wr_stamp = 1'b0;
    case (state)
      S_FINISH: begin
        if (hit_found) begin
          wr_idx   = hit_idx;
          wr_en    = (hit_count != lbc_pkg::COUNT_MAX);
          wr_count = hit_count + 1'b1;
        end else if (free_found) begin
          wr_idx   = victim_idx;
          wr_en    = 1'b1;
          wr_tag   = 1'b1;
          wr_count = lbc_pkg::CNT_W'(1);
        end
      end
      S_UPDATE: begin
        if (!req_oor) begin
          if (req_mode == lbc_pkg::MODE_PIN) begin
            wr_en    = (ent.count != lbc_pkg::COUNT_MAX);
            wr_count = ent.count + 1'b1;
          end else if (req_mode != lbc_pkg::MODE_GET) begin
            wr_en    = (ent.count != '0);
            wr_count = ent.count - 1'b1;
            wr_stamp = (req_mode == lbc_pkg::MODE_RELEASE) &&
                       (ent.count == lbc_pkg::CNT_W'(1));
          end
        end
      end
      default: ;
    endcase
  end

  // tag store write port; reset clears counts, times and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbc_pkg::BUFFERS; i++) begin
        ref_count[i]      <= '0;
        release_time[i]   <= '0;
        contents_valid[i] <= 1'b0;
      end
    end else if (wr_en) begin
      ref_count[wr_idx] <= wr_count;
      if (wr_tag) begin
        tag_device[wr_idx]     <= req_device;
        tag_block[wr_idx]      <= req_block;
        contents_valid[wr_idx] <= 1'b1;
      end
      if (wr_stamp) begin
        release_time[wr_idx] <= req_now;
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      cnt        <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_mode   <= lbc_pkg::lbc_mode_t'(mode);
            req_device <= device;
            req_block  <= block_number;
            req_index  <= buffer_index;
            req_now    <= now;
            cnt        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            victim_time <= '0;
            state      <= (lbc_pkg::lbc_mode_t'(mode) == lbc_pkg::MODE_GET) ?
                          S_SCAN : S_UPDATE;
          end
        end
        S_SCAN: begin
          if (!hit_found && pick.is_match) begin
            hit_found <= 1'b1;
            hit_idx   <= cnt;
            hit_count <= ent.count;
          end
          if (pick.is_better_free) begin
            free_found  <= 1'b1;
            victim_idx  <= cnt;
            victim_time <= ent.stamp;
          end
          if (cnt == IW'(lbc_pkg::BUFFERS - 1)) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FINISH: begin
          done <= 1'b1;
          if (hit_found) begin
            slot       <= hit_slot_w[4:0];
            hit        <= 1'b1;
            needs_fill <= 1'b0;
            status     <= (hit_count == lbc_pkg::COUNT_MAX) ?
                          lbc_pkg::STAT_COUNT : lbc_pkg::STAT_OK;
          end else if (free_found) begin
            slot       <= victim_slot_w[4:0];
            hit        <= 1'b0;
            needs_fill <= 1'b1;
            status     <= lbc_pkg::STAT_OK;
          end else begin
            slot       <= '0;
            hit        <= 1'b0;
            needs_fill <= 1'b0;
            status     <= lbc_pkg::STAT_NO_FREE;
          end
          state <= S_IDLE;
        end
        S_UPDATE: begin
          done       <= 1'b1;
          slot       <= req_index;
          hit        <= 1'b0;
          needs_fill <= 1'b0;
          if (req_oor) begin
            status <= lbc_pkg::STAT_COUNT;
          end else if (req_mode == lbc_pkg::MODE_PIN) begin
            status <= (ent.count == lbc_pkg::COUNT_MAX) ?
                      lbc_pkg::STAT_COUNT : lbc_pkg::STAT_OK;
          end else begin
            status <= (ent.count == '0) ? lbc_pkg::STAT_COUNT : lbc_pkg::STAT_OK;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
